@@ sv/elx_pkg.sv @@
// Shared types, codes and character classification for the expression lexer.
package elx_pkg;

    localparam int ELX_TEXT_LEN = 65536;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_ZEROX,
        MODE_IDENT,
        MODE_HOLD_TOP,
        MODE_HOLD_ID
    } t_scan_mode;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_OCT,
        RADIX_HEX
    } t_radix;

    localparam logic [1:0] KIND_NUM   = 2'd0;
    localparam logic [1:0] KIND_OP    = 2'd1;
    localparam logic [1:0] KIND_IDENT = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_EQ   = 3'd6;
    localparam logic [2:0] OP_NE   = 3'd7;

    // Single-byte operator index, or this value when the byte is no operator.
    localparam logic [3:0] SOP_NONE = 4'd8;
    // Digit value returned for a byte that is no hex digit.
    localparam logic [4:0] DIG_NONE = 5'd16;

    localparam int MAX_RES = 4;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_tok_in;

    typedef struct packed {
        logic [1:0]         token_kind;
        logic [2:0]         operator_code;
        logic signed [31:0] number_value;
        logic [15:0]        start_offset;
        logic [16:0]        token_length;
        logic               last_of_run;
    } t_tok_out;

    // All results caused by one input byte, in order.
    typedef struct packed {
        t_tok_out [MAX_RES-1:0] res;
        logic [2:0]             count;
    } t_tok_bundle;

    function automatic logic f_is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic logic [3:0] f_single_op(input logic [7:0] c);
        logic [3:0] r;
        unique case (c)
            "+":     r = 4'd0;
            "-":     r = 4'd1;
            "*":     r = 4'd2;
            "/":     r = 4'd3;
            "(":     r = 4'd4;
            ")":     r = 4'd5;
            default: r = SOP_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] f_digit_val(input logic [7:0] c);
        logic [4:0] r;
        if (c >= "0" && c <= "9") begin
            r = 5'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            r = 5'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "F") begin
            r = 5'(c - "A" + 8'd10);
        end else begin
            r = DIG_NONE;
        end
        return r;
    endfunction

endpackage

@@ sv/elx_core.sv @@
// Lexer state and the per-byte step that forms all results of one byte.
module elx_core #(
    parameter int TEXT_LEN = elx_pkg::ELX_TEXT_LEN
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  elx_pkg::t_tok_in    i_item,
    output elx_pkg::t_tok_bundle o_bundle
);
    import elx_pkg::*;

    localparam int PW = $clog2(TEXT_LEN);
    localparam int LW = $clog2(TEXT_LEN + 1);
    localparam logic [62:0] ACC_MAX = {63{1'b1}};

    t_scan_mode  r_mode, n_mode;
    logic [62:0] r_acc, n_acc;
    t_radix      r_radix, n_radix;
    logic        r_held_eq, n_held_eq;
    logic [PW-1:0] r_tb, n_tb;
    logic [LW-1:0] r_rl, n_rl;
    logic [PW-1:0] r_pos, n_pos;

    t_tok_out [MAX_RES-1:0] n_res;
    logic [2:0]             n_cnt;

    function automatic logic [PW-1:0] f_pos_inc(input logic [PW-1:0] p);
        return (p == PW'(TEXT_LEN - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] f_pos_dec(input logic [PW-1:0] p);
        return (p == '0) ? PW'(TEXT_LEN - 1) : p - 1'b1;
    endfunction

    function automatic logic [LW-1:0] f_len_inc(input logic [LW-1:0] l);
        return (l < LW'(TEXT_LEN)) ? l + 1'b1 : l;
    endfunction

    function automatic logic [15:0] f_pos16(input logic [PW-1:0] p);
        logic [PW+15:0] w;
        w = {16'b0, p};
        return w[15:0];
    endfunction

    function automatic logic [16:0] f_len17(input logic [LW-1:0] l);
        logic [LW+16:0] w;
        w = {17'b0, l};
        return w[16:0];
    endfunction

    function automatic t_tok_out f_tok(input logic [1:0] kind, input logic [2:0] op,
                                       input logic [31:0] val, input logic [PW-1:0] st,
                                       input logic [LW-1:0] len);
        t_tok_out t;
        t.token_kind    = kind;
        t.operator_code = op;
        t.number_value  = val;
        t.start_offset  = f_pos16(st);
        t.token_length  = f_len17(len);
        t.last_of_run   = 1'b0;
        return t;
    endfunction

    // Saturating acc * base + digit; the product of shifts stays within 67 bits.
    logic [4:0]  w_dv;
    logic [3:0]  w_op;
    logic        w_in_radix;
    logic [66:0] w_prod, w_sum;
    logic [62:0] w_acc_next;

    assign w_dv = f_digit_val(i_item.text_byte);
    assign w_op = f_single_op(i_item.text_byte);

    always_comb begin
        unique case (r_radix)
            RADIX_HEX: begin
                w_in_radix = w_dv < 5'd16;
                w_prod     = {r_acc, 4'b0};
            end
            RADIX_OCT: begin
                w_in_radix = w_dv < 5'd8;
                w_prod     = {1'b0, r_acc, 3'b0};
            end
            default: begin
                w_in_radix = w_dv < 5'd10;
                w_prod     = {1'b0, r_acc, 3'b0} + {3'b0, r_acc, 1'b0};
            end
        endcase
        w_sum      = w_prod + 67'(w_dv);
        w_acc_next = (w_sum > 67'(ACC_MAX)) ? ACC_MAX : w_sum[62:0];
    end

    always_comb begin
        logic [7:0] c;
        logic       do_start;
        logic       do_ident;
        logic [2:0] op_eqne;
        c        = i_item.text_byte;
        do_start = 1'b0;
        do_ident = 1'b0;
        op_eqne  = r_held_eq ? OP_EQ : OP_NE;
        n_mode    = r_mode;
        n_acc     = r_acc;
        n_radix   = r_radix;
        n_held_eq = r_held_eq;
        n_tb      = r_tb;
        n_rl      = r_rl;
        n_pos     = r_pos;
        n_res     = '0;
        n_cnt     = '0;

        unique case (r_mode)
            MODE_NUM: begin
                if (w_in_radix) begin
                    n_acc = w_acc_next;
                    n_rl  = f_len_inc(r_rl);
                end else if (r_radix == RADIX_OCT && r_rl == LW'(1)
                             && (c | 8'h20) == "x") begin
                    n_mode = MODE_ZEROX;
                    n_rl   = LW'(2);
                end else begin
                    n_res[n_cnt[1:0]] = f_tok(KIND_NUM, OP_NONE, r_acc[31:0], r_tb, r_rl);
                    n_cnt = n_cnt + 3'd1;
                    do_start = 1'b1;
                end
            end
            MODE_ZEROX: begin
                if (w_dv < 5'd16) begin
                    n_mode  = MODE_NUM;
                    n_radix = RADIX_HEX;
                    n_acc   = 63'(w_dv);
                    n_rl    = LW'(3);
                end else begin
                    n_res[n_cnt[1:0]] = f_tok(KIND_NUM, OP_NONE, 32'd0, r_tb, LW'(1));
                    n_cnt = n_cnt + 3'd1;
                    n_tb   = f_pos_inc(r_tb);
                    n_rl   = LW'(1);
                    n_mode = MODE_IDENT;
                    do_ident = 1'b1;
                end
            end
            MODE_IDENT: begin
                do_ident = 1'b1;
            end
            MODE_HOLD_TOP: begin
                if (c == "=") begin
                    n_res[n_cnt[1:0]] = f_tok(KIND_OP, op_eqne, 32'd0, r_tb, LW'(2));
                    n_cnt = n_cnt + 3'd1;
                    n_mode = MODE_IDLE;
                end else begin
                    n_mode = MODE_IDENT;
                    n_rl   = LW'(1);
                    do_ident = 1'b1;
                end
            end
            MODE_HOLD_ID: begin
                if (c == "=") begin
                    n_res[n_cnt[1:0]] = f_tok(KIND_IDENT, OP_NONE, 32'd0, r_tb, r_rl);
                    n_cnt = n_cnt + 3'd1;
                    n_res[n_cnt[1:0]] = f_tok(KIND_OP, op_eqne, 32'd0, f_pos_dec(r_pos),
                                              LW'(2));
                    n_cnt = n_cnt + 3'd1;
                    n_mode = MODE_IDLE;
                end else begin
                    n_rl   = f_len_inc(r_rl);
                    n_mode = MODE_IDENT;
                    do_ident = 1'b1;
                end
            end
            default: begin
                do_start = 1'b1;
            end
        endcase

        // A byte that begins a new token.
        if (do_start) begin
            n_mode = MODE_IDLE;
            if (!f_is_ws(c)) begin
                n_tb = r_pos;
                if (c >= "0" && c <= "9") begin
                    n_mode  = MODE_NUM;
                    n_radix = (c == "0") ? RADIX_OCT : RADIX_DEC;
                    n_acc   = 63'(w_dv);
                    n_rl    = LW'(1);
                end else if (w_op != SOP_NONE) begin
                    n_res[n_cnt[1:0]] = f_tok(KIND_OP, w_op[2:0], 32'd0, r_pos, LW'(1));
                    n_cnt = n_cnt + 3'd1;
                end else if (c == "=" || c == "!") begin
                    n_mode    = MODE_HOLD_TOP;
                    n_held_eq = (c == "=");
                end else begin
                    n_mode = MODE_IDENT;
                    n_rl   = LW'(1);
                end
            end
        end

        // A byte that continues or ends an identifier.
        if (do_ident) begin
            if (f_is_ws(c)) begin
                n_res[n_cnt[1:0]] = f_tok(KIND_IDENT, OP_NONE, 32'd0, n_tb, n_rl);
                n_cnt = n_cnt + 3'd1;
                n_mode = MODE_IDLE;
            end else if (w_op != SOP_NONE) begin
                n_res[n_cnt[1:0]] = f_tok(KIND_IDENT, OP_NONE, 32'd0, n_tb, n_rl);
                n_cnt = n_cnt + 3'd1;
                n_res[n_cnt[1:0]] = f_tok(KIND_OP, w_op[2:0], 32'd0, r_pos, LW'(1));
                n_cnt = n_cnt + 3'd1;
                n_mode = MODE_IDLE;
            end else if (c == "=" || c == "!") begin
                n_held_eq = (c == "=");
                n_mode    = MODE_HOLD_ID;
            end else begin
                n_rl = f_len_inc(n_rl);
            end
        end

        // The final byte closes any open token, adds the end marker and clears the state.
        if (i_item.final_byte) begin
            unique case (n_mode)
                MODE_NUM: begin
                    n_res[n_cnt[1:0]] = f_tok(KIND_NUM, OP_NONE, n_acc[31:0], n_tb, n_rl);
                    n_cnt = n_cnt + 3'd1;
                end
                MODE_ZEROX: begin
                    n_res[n_cnt[1:0]] = f_tok(KIND_NUM, OP_NONE, 32'd0, n_tb, LW'(1));
                    n_cnt = n_cnt + 3'd1;
                    n_res[n_cnt[1:0]] = f_tok(KIND_IDENT, OP_NONE, 32'd0, f_pos_inc(n_tb),
                                              LW'(1));
                    n_cnt = n_cnt + 3'd1;
                end
                MODE_IDENT: begin
                    n_res[n_cnt[1:0]] = f_tok(KIND_IDENT, OP_NONE, 32'd0, n_tb, n_rl);
                    n_cnt = n_cnt + 3'd1;
                end
                MODE_HOLD_TOP: begin
                    n_res[n_cnt[1:0]] = f_tok(KIND_IDENT, OP_NONE, 32'd0, n_tb, LW'(1));
                    n_cnt = n_cnt + 3'd1;
                end
                MODE_HOLD_ID: begin
                    n_res[n_cnt[1:0]] = f_tok(KIND_IDENT, OP_NONE, 32'd0, n_tb,
                                              f_len_inc(n_rl));
                    n_cnt = n_cnt + 3'd1;
                end
                default: begin
                end
            endcase
            n_res[n_cnt[1:0]] = f_tok(KIND_END, OP_NONE, 32'd0, f_pos_inc(r_pos), '0);
            n_cnt = n_cnt + 3'd1;
            n_mode    = MODE_IDLE;
            n_acc     = '0;
            n_radix   = RADIX_DEC;
            n_held_eq = 1'b0;
            n_tb      = '0;
            n_rl      = '0;
            n_pos     = '0;
        end else begin
            n_pos = f_pos_inc(r_pos);
        end

        if (n_cnt != 3'd0) begin
            n_res[2'(n_cnt - 3'd1)].last_of_run = 1'b1;
        end
    end

    assign o_bundle.res   = n_res;
    assign o_bundle.count = n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_acc     <= '0;
            r_radix   <= RADIX_DEC;
            r_held_eq <= 1'b0;
            r_tb      <= '0;
            r_rl      <= '0;
            r_pos     <= '0;
        end else if (i_accept) begin
            r_mode    <= n_mode;
            r_acc     <= n_acc;
            r_radix   <= n_radix;
            r_held_eq <= n_held_eq;
            r_tb      <= n_tb;
            r_rl      <= n_rl;
            r_pos     <= n_pos;
        end
    end

endmodule

@@ sv/elx_out.sv @@
// Two-entry buffer of result groups and the serializer that sends one token a cycle unless stalled.
module elx_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  elx_pkg::t_tok_bundle i_bundle,
    output logic                 o_full,
    output logic                 o_valid,
    input  logic                 i_stall,
    output elx_pkg::t_tok_out    o_data
);
    import elx_pkg::*;

    t_tok_bundle r_buf [2];
    logic        r_wr, r_rd;
    logic [1:0]  r_cnt, n_cnt;
    logic [1:0]  r_idx;
    t_tok_bundle w_cur;
    logic        w_take;
    logic        w_done;

    assign w_cur   = r_buf[r_rd];
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = w_cur.res[r_idx];
    assign w_take  = o_valid && !i_stall;
    // The group is retired with the transaction of its last token.
    assign w_done  = w_take && (r_idx == w_cur.count[1:0] - 2'd1);
    assign n_cnt   = r_cnt + {1'b0, i_push} - {1'b0, w_done};

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
            r_idx <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (w_done) begin
                r_rd  <= ~r_rd;
                r_idx <= '0;
            end else if (w_take) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

@@ sv/expression_lexer.sv @@
// Top level of the streaming expression lexer.
// The input channel takes one text byte per transaction, with final_byte set on
// the byte that ends the text. The output channel gives tokens (number, operator,
// identifier, end of text) with offset, length and value; last_of_run marks the
// last token caused by one byte. A byte may cause zero to four tokens.
// Each accepted byte is lexed in the cycle it is accepted: the scan state is
// updated and all its tokens are written as one group into a two-entry buffer.
// The first token of a byte is offered from the registered buffer once all earlier groups have been sent.
// One byte is taken every cycle while each byte yields at most one token and the
// receiver does not stall; the serializer sends tokens one a cycle unless the
// receiver stalls; the input stalls only while both buffer entries are occupied.
// A receiver stall holds the current token and fills the buffer, after which the
// input is stalled until a group has been sent.
// Reset clears the scan state, the byte position and the buffer; after a final
// byte the scan state returns to its reset value.
module expression_lexer #(
    parameter int TEXT_LEN = elx_pkg::ELX_TEXT_LEN
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  elx_pkg::t_tok_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output elx_pkg::t_tok_out o_out_data
);
    import elx_pkg::*;

    logic        w_full;
    logic        w_accept;
    logic        w_push;
    t_tok_bundle w_bundle;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;
    assign w_push     = w_accept && (w_bundle.count != 3'd0);

    elx_core #(
        .TEXT_LEN(TEXT_LEN)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_data),
        .o_bundle (w_bundle)
    );

    elx_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_bundle (w_bundle),
        .o_full   (w_full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_data   (o_out_data)
    );

endmodule
